@@ rtl/sbb_pkg.sv @@
// Shared types, kind codes and saturating Q16.16 arithmetic for the bounding box block.
package sbb_pkg;

  localparam int unsigned QW    = 32;
  localparam int unsigned KindW = 5;
  localparam int unsigned WidW  = 31;

  localparam logic signed [QW-1:0] QMin = {1'b1, {(QW-1){1'b0}}};
  localparam logic signed [QW-1:0] QMax = {1'b0, {(QW-1){1'b1}}};

  localparam logic [KindW-1:0] KIND_CIRCLE   = 5'd0;
  localparam logic [KindW-1:0] KIND_BOX      = 5'd1;
  localparam logic [KindW-1:0] KIND_SEGMENT  = 5'd2;
  localparam logic [KindW-1:0] KIND_TRIANGLE = 5'd3;
  localparam logic [KindW-1:0] KIND_BEZIER2  = 5'd4;
  localparam logic [KindW-1:0] KIND_BEZIER3  = 5'd5;
  localparam logic [KindW-1:0] KIND_ELLIPSE  = 5'd6;
  localparam logic [KindW-1:0] KIND_ARC      = 5'd7;
  localparam logic [KindW-1:0] KIND_RBOX     = 5'd8;
  localparam logic [KindW-1:0] KIND_RHOMBUS  = 5'd9;
  localparam logic [KindW-1:0] KIND_POLYGON  = 5'd10;
  localparam logic [KindW-1:0] KIND_STAR     = 5'd11;
  localparam logic [KindW-1:0] KIND_PIE      = 5'd12;
  localparam logic [KindW-1:0] KIND_RING     = 5'd13;
  localparam logic [KindW-1:0] KIND_HEART    = 5'd14;
  localparam logic [KindW-1:0] KIND_CROSS    = 5'd15;
  localparam logic [KindW-1:0] KIND_ROUNDX   = 5'd16;
  localparam logic [KindW-1:0] KIND_CAPSULE  = 5'd17;
  localparam logic [KindW-1:0] KIND_MOON     = 5'd18;
  localparam logic [KindW-1:0] KIND_EGG      = 5'd19;

  typedef struct packed {
    logic [KindW-1:0]       shape_kind;
    logic signed [QW-1:0]   param_0;
    logic signed [QW-1:0]   param_1;
    logic signed [QW-1:0]   param_2;
    logic signed [QW-1:0]   param_3;
    logic signed [QW-1:0]   param_4;
    logic signed [QW-1:0]   param_5;
    logic signed [QW-1:0]   param_6;
    logic signed [QW-1:0]   param_7;
    logic [WidW-1:0]        stroke_width;
    logic [WidW-1:0]        corner_round;
  } sbb_prim_t;

  typedef struct packed {
    logic signed [QW-1:0] min_x;
    logic signed [QW-1:0] min_y;
    logic signed [QW-1:0] max_x;
    logic signed [QW-1:0] max_y;
  } sbb_box_t;

  function automatic logic signed [QW-1:0] sat_wide(input logic signed [QW:0] s);
    logic signed [QW-1:0] r;
    if (s[QW] != s[QW-1]) begin
      r = s[QW] ? QMin : QMax;
    end else begin
      r = s[QW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [QW-1:0] sat_add(input logic signed [QW-1:0] a,
                                                   input logic signed [QW-1:0] b);
    logic signed [QW:0] s;
    s = {a[QW-1], a} + {b[QW-1], b};
    return sat_wide(s);
  endfunction

  function automatic logic signed [QW-1:0] sat_sub(input logic signed [QW-1:0] a,
                                                   input logic signed [QW-1:0] b);
    logic signed [QW:0] s;
    s = {a[QW-1], a} - {b[QW-1], b};
    return sat_wide(s);
  endfunction

  function automatic logic signed [QW-1:0] smin(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [QW-1:0] smax(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // Floor of 1.5 times the value: 3v as an arithmetic shift right by one.
  function automatic logic signed [QW-1:0] three_halves(input logic signed [QW-1:0] v);
    logic signed [QW+1:0] t;
    logic signed [QW:0]   h;
    t = {{2{v[QW-1]}}, v} + {v[QW-1], v, 1'b0};
    h = t[QW+1:1];
    return sat_wide(h);
  endfunction

endpackage

@@ rtl/sbb_in_if.sv @@
// Primitive input channel: valid, ready and the shape description.
interface sbb_in_if;
  import sbb_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KindW-1:0]     shape_kind;
  logic signed [QW-1:0] param_0;
  logic signed [QW-1:0] param_1;
  logic signed [QW-1:0] param_2;
  logic signed [QW-1:0] param_3;
  logic signed [QW-1:0] param_4;
  logic signed [QW-1:0] param_5;
  logic signed [QW-1:0] param_6;
  logic signed [QW-1:0] param_7;
  logic [WidW-1:0]      stroke_width;
  logic [WidW-1:0]      corner_round;

  modport source (
    output valid, shape_kind, param_0, param_1, param_2, param_3,
           param_4, param_5, param_6, param_7, stroke_width, corner_round,
    input  ready
  );

  modport sink (
    input  valid, shape_kind, param_0, param_1, param_2, param_3,
           param_4, param_5, param_6, param_7, stroke_width, corner_round,
    output ready
  );
endinterface

@@ rtl/sbb_out_if.sv @@
// Bounding box output channel: valid, ready and the four box edges.
interface sbb_out_if;
  import sbb_pkg::*;

  logic                 valid;
  logic                 ready;
  logic signed [QW-1:0] min_x;
  logic signed [QW-1:0] min_y;
  logic signed [QW-1:0] max_x;
  logic signed [QW-1:0] max_y;

  modport source (
    output valid, min_x, min_y, max_x, max_y,
    input  ready
  );

  modport sink (
    input  valid, min_x, min_y, max_x, max_y,
    output ready
  );
endinterface

@@ rtl/shape_bounding_box.sv @@
// Top level: axis-aligned bounding box of one drawing primitive per transfer.
//
//   Channel  Direction  Payload
//   in_i     sink       shape_kind, param_0..param_7, stroke_width, corner_round
//   out_o    source     min_x, min_y, max_x, max_y
//
// One primitive is taken per cycle unless a stalled output holds the flow.
// The path is an input register, the per-kind saturating add and compare logic, and the
// result register. Reset clears both valid flags and leaves the block ready at once.
// A stalled output holds its box; one more primitive is then taken into the input register.
module shape_bounding_box (
  input logic     clk_i,
  input logic     rst_ni,
  sbb_in_if.sink  in_i,
  sbb_out_if.source out_o
);
  import sbb_pkg::*;

  logic                 s1_valid_q;
  sbb_prim_t            s1_q;
  logic                 out_valid_q;
  sbb_box_t             box_q;
  sbb_box_t             box_d;
  logic                 out_adv;
  logic                 s1_adv;

  logic signed [QW-1:0] pad;
  logic signed [QW-1:0] rnd;
  logic signed [QW-1:0] r;
  logic signed [QW-1:0] hw;
  logic signed [QW-1:0] hh;
  logic                 boxed;

  assign out_adv    = !out_valid_q || out_o.ready;
  assign s1_adv     = !s1_valid_q || out_adv;
  assign in_i.ready = s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= in_i.valid;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_i.valid) begin
      s1_q.shape_kind   <= in_i.shape_kind;
      s1_q.param_0      <= in_i.param_0;
      s1_q.param_1      <= in_i.param_1;
      s1_q.param_2      <= in_i.param_2;
      s1_q.param_3      <= in_i.param_3;
      s1_q.param_4      <= in_i.param_4;
      s1_q.param_5      <= in_i.param_5;
      s1_q.param_6      <= in_i.param_6;
      s1_q.param_7      <= in_i.param_7;
      s1_q.stroke_width <= in_i.stroke_width;
      s1_q.corner_round <= in_i.corner_round;
    end
    if (out_adv && s1_valid_q) begin
      box_q <= box_d;
    end
  end

  assign pad = {2'b00, s1_q.stroke_width[WidW-1:1]};
  assign rnd = {1'b0, s1_q.corner_round};

  always_comb begin
    box_d.min_x = QMin;
    box_d.min_y = QMin;
    box_d.max_x = QMax;
    box_d.max_y = QMax;
    r     = '0;
    hw    = '0;
    hh    = '0;
    boxed = 1'b0;
    case (s1_q.shape_kind)
      KIND_CIRCLE, KIND_POLYGON, KIND_STAR: begin
        r     = sat_add(s1_q.param_2, pad);
        boxed = 1'b1;
      end
      KIND_BOX: begin
        hw    = sat_add(sat_add(s1_q.param_2, rnd), pad);
        hh    = sat_add(sat_add(s1_q.param_3, rnd), pad);
        boxed = 1'b1;
      end
      KIND_SEGMENT: begin
        box_d.min_x = sat_sub(smin(s1_q.param_0, s1_q.param_2), pad);
        box_d.min_y = sat_sub(smin(s1_q.param_1, s1_q.param_3), pad);
        box_d.max_x = sat_add(smax(s1_q.param_0, s1_q.param_2), pad);
        box_d.max_y = sat_add(smax(s1_q.param_1, s1_q.param_3), pad);
      end
      KIND_TRIANGLE, KIND_BEZIER2: begin
        box_d.min_x = sat_sub(smin(smin(s1_q.param_0, s1_q.param_2), s1_q.param_4), pad);
        box_d.min_y = sat_sub(smin(smin(s1_q.param_1, s1_q.param_3), s1_q.param_5), pad);
        box_d.max_x = sat_add(smax(smax(s1_q.param_0, s1_q.param_2), s1_q.param_4), pad);
        box_d.max_y = sat_add(smax(smax(s1_q.param_1, s1_q.param_3), s1_q.param_5), pad);
      end
      KIND_BEZIER3: begin
        box_d.min_x = sat_sub(smin(smin(s1_q.param_0, s1_q.param_2),
                                   smin(s1_q.param_4, s1_q.param_6)), pad);
        box_d.min_y = sat_sub(smin(smin(s1_q.param_1, s1_q.param_3),
                                   smin(s1_q.param_5, s1_q.param_7)), pad);
        box_d.max_x = sat_add(smax(smax(s1_q.param_0, s1_q.param_2),
                                   smax(s1_q.param_4, s1_q.param_6)), pad);
        box_d.max_y = sat_add(smax(smax(s1_q.param_1, s1_q.param_3),
                                   smax(s1_q.param_5, s1_q.param_7)), pad);
      end
      KIND_ELLIPSE: begin
        box_d.min_x = sat_sub(sat_sub(s1_q.param_0, s1_q.param_2), pad);
        box_d.min_y = sat_sub(sat_sub(s1_q.param_1, s1_q.param_3), pad);
        box_d.max_x = sat_add(sat_add(s1_q.param_0, s1_q.param_2), pad);
        box_d.max_y = sat_add(sat_add(s1_q.param_1, s1_q.param_3), pad);
      end
      KIND_ARC: begin
        r     = sat_add(smax(s1_q.param_4, s1_q.param_5), pad);
        boxed = 1'b1;
      end
      KIND_RBOX: begin
        r     = smax(smax(s1_q.param_4, s1_q.param_5), smax(s1_q.param_6, s1_q.param_7));
        hw    = sat_add(sat_add(s1_q.param_2, r), pad);
        hh    = sat_add(sat_add(s1_q.param_3, r), pad);
        boxed = 1'b1;
      end
      KIND_RHOMBUS: begin
        hw    = sat_add(s1_q.param_2, pad);
        hh    = sat_add(s1_q.param_3, pad);
        boxed = 1'b1;
      end
      KIND_PIE: begin
        r     = sat_add(s1_q.param_4, pad);
        boxed = 1'b1;
      end
      KIND_RING: begin
        r     = sat_add(sat_add(s1_q.param_4, s1_q.param_5), pad);
        boxed = 1'b1;
      end
      KIND_HEART: begin
        r     = sat_add(three_halves(s1_q.param_2), pad);
        boxed = 1'b1;
      end
      KIND_CROSS: begin
        r     = sat_add(smax(s1_q.param_2, s1_q.param_3), pad);
        boxed = 1'b1;
      end
      KIND_ROUNDX: begin
        r     = sat_add(sat_add(s1_q.param_2, s1_q.param_3), pad);
        boxed = 1'b1;
      end
      KIND_CAPSULE: begin
        r           = sat_add(s1_q.param_4, pad);
        box_d.min_x = sat_sub(smin(s1_q.param_0, s1_q.param_2), r);
        box_d.min_y = sat_sub(smin(s1_q.param_1, s1_q.param_3), r);
        box_d.max_x = sat_add(smax(s1_q.param_0, s1_q.param_2), r);
        box_d.max_y = sat_add(smax(s1_q.param_1, s1_q.param_3), r);
      end
      KIND_MOON: begin
        r           = sat_add(smax(s1_q.param_3, s1_q.param_4), pad);
        box_d.min_x = sat_sub(s1_q.param_0, r);
        box_d.min_y = sat_sub(s1_q.param_1, r);
        box_d.max_x = sat_add(sat_add(s1_q.param_0, r), s1_q.param_2);
        box_d.max_y = sat_add(s1_q.param_1, r);
      end
      KIND_EGG: begin
        r           = sat_add(smax(s1_q.param_2, s1_q.param_3), pad);
        box_d.min_x = sat_sub(s1_q.param_0, r);
        box_d.min_y = sat_sub(s1_q.param_1, r);
        box_d.max_x = sat_add(s1_q.param_0, r);
        box_d.max_y = sat_add(sat_add(s1_q.param_1, r), s1_q.param_2);
      end
      default: begin
        boxed = 1'b0;
      end
    endcase
    // Centred kinds use the same radius on both axes.
    if (boxed && (hw == '0) && (hh == '0) && (s1_q.shape_kind != KIND_BOX) &&
        (s1_q.shape_kind != KIND_RBOX) && (s1_q.shape_kind != KIND_RHOMBUS)) begin
      hw = r;
      hh = r;
    end
    if (boxed) begin
      box_d.min_x = sat_sub(s1_q.param_0, hw);
      box_d.min_y = sat_sub(s1_q.param_1, hh);
      box_d.max_x = sat_add(s1_q.param_0, hw);
      box_d.max_y = sat_add(s1_q.param_1, hh);
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.min_x = box_q.min_x;
  assign out_o.min_y = box_q.min_y;
  assign out_o.max_x = box_q.max_x;
  assign out_o.max_y = box_q.max_y;

endmodule

@@ rtl/sbb_checker.sv @@
// Port-level assertions for the bounding box block and the bind that attaches them.
module sbb_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input logic [127:0]    out_box_i
);
  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] occ_q;
  logic [1:0] occ_d;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  always_comb begin
    occ_d = occ_q;
    if (in_xfer && !out_xfer) begin
      occ_d = occ_q + 2'd1;
    end else if (!in_xfer && out_xfer) begin
      occ_d = occ_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 2'd0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // A stalled result keeps its valid and its box.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_box_i))
    else $error("stalled result changed");

  // At most two primitives are ever held inside.
  a_occ_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q != 2'd3)
    else $error("more than two primitives held");

  // A result is shown only for a primitive that was taken in.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> occ_q != 2'd0)
    else $error("result without a primitive");

  // An empty output stage never blocks the input.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with output empty");

  // A transfer taken during a stall fills the input register, so a continued stall blocks.
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i && in_xfer ##1 out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken with both stages full");

endmodule

bind shape_bounding_box sbb_checker u_sbb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_box_i   ({out_o.min_x, out_o.min_y, out_o.max_x, out_o.max_y})
);

@@ tb/shape_bounding_box_checker.sv @@
`timescale 1ns / 100ps
// Watches both channels, predicts each bounding box and compares it field by field.
module shape_bounding_box_checker (
  input  logic clk_i,
  input  logic rst_ni,
  sbb_in_if    prim_i,
  sbb_out_if   box_i,
  output int   fail_count_o,
  output int   pending_o
);
  import sbb_pkg::*;

  localparam longint QLo = longint'(QMin);
  localparam longint QHi = longint'(QMax);

  sbb_box_t box_q[$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic longint clamp_q(input longint v);
    if (v < QLo) return QLo;
    if (v > QHi) return QHi;
    return v;
  endfunction

  function automatic longint q_plus(input longint a, input longint b);
    return clamp_q(a + b);
  endfunction

  function automatic longint q_minus(input longint a, input longint b);
    return clamp_q(a - b);
  endfunction

  function automatic longint lo_of(input longint a, input longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint hi_of(input longint a, input longint b);
    return (a > b) ? a : b;
  endfunction

  // Floor of 1.5 times the scale, taken as an arithmetic shift of 3v.
  function automatic longint heart_radius(input longint v);
    return clamp_q((3 * v) >>> 1);
  endfunction

  function automatic sbb_box_t bbox_of(input sbb_prim_t p);
    longint   c[8];
    longint   pad, rnd, r, hw, hh, x0, y0, x1, y1;
    bit       centred, boxed;
    sbb_box_t b;
    c[0] = longint'($signed(p.param_0));
    c[1] = longint'($signed(p.param_1));
    c[2] = longint'($signed(p.param_2));
    c[3] = longint'($signed(p.param_3));
    c[4] = longint'($signed(p.param_4));
    c[5] = longint'($signed(p.param_5));
    c[6] = longint'($signed(p.param_6));
    c[7] = longint'($signed(p.param_7));
    pad = longint'(p.stroke_width >> 1);
    rnd = longint'(p.corner_round);
    r = 0;
    hw = 0;
    hh = 0;
    x0 = QLo;
    y0 = QLo;
    x1 = QHi;
    y1 = QHi;
    centred = 1'b0;
    boxed = 1'b0;
    case (p.shape_kind)
      KIND_CIRCLE, KIND_POLYGON, KIND_STAR: begin
        r = q_plus(c[2], pad);
        centred = 1'b1;
      end
      KIND_BOX: begin
        hw = q_plus(q_plus(c[2], rnd), pad);
        hh = q_plus(q_plus(c[3], rnd), pad);
        boxed = 1'b1;
      end
      KIND_SEGMENT: begin
        x0 = q_minus(lo_of(c[0], c[2]), pad);
        y0 = q_minus(lo_of(c[1], c[3]), pad);
        x1 = q_plus(hi_of(c[0], c[2]), pad);
        y1 = q_plus(hi_of(c[1], c[3]), pad);
      end
      KIND_TRIANGLE, KIND_BEZIER2: begin
        x0 = q_minus(lo_of(lo_of(c[0], c[2]), c[4]), pad);
        y0 = q_minus(lo_of(lo_of(c[1], c[3]), c[5]), pad);
        x1 = q_plus(hi_of(hi_of(c[0], c[2]), c[4]), pad);
        y1 = q_plus(hi_of(hi_of(c[1], c[3]), c[5]), pad);
      end
      KIND_BEZIER3: begin
        x0 = q_minus(lo_of(lo_of(c[0], c[2]), lo_of(c[4], c[6])), pad);
        y0 = q_minus(lo_of(lo_of(c[1], c[3]), lo_of(c[5], c[7])), pad);
        x1 = q_plus(hi_of(hi_of(c[0], c[2]), hi_of(c[4], c[6])), pad);
        y1 = q_plus(hi_of(hi_of(c[1], c[3]), hi_of(c[5], c[7])), pad);
      end
      KIND_ELLIPSE: begin
        x0 = q_minus(q_minus(c[0], c[2]), pad);
        y0 = q_minus(q_minus(c[1], c[3]), pad);
        x1 = q_plus(q_plus(c[0], c[2]), pad);
        y1 = q_plus(q_plus(c[1], c[3]), pad);
      end
      KIND_ARC: begin
        r = q_plus(hi_of(c[4], c[5]), pad);
        centred = 1'b1;
      end
      KIND_RBOX: begin
        r  = hi_of(hi_of(c[4], c[5]), hi_of(c[6], c[7]));
        hw = q_plus(q_plus(c[2], r), pad);
        hh = q_plus(q_plus(c[3], r), pad);
        boxed = 1'b1;
      end
      KIND_RHOMBUS: begin
        hw = q_plus(c[2], pad);
        hh = q_plus(c[3], pad);
        boxed = 1'b1;
      end
      KIND_PIE: begin
        r = q_plus(c[4], pad);
        centred = 1'b1;
      end
      KIND_RING: begin
        r = q_plus(q_plus(c[4], c[5]), pad);
        centred = 1'b1;
      end
      KIND_HEART: begin
        r = q_plus(heart_radius(c[2]), pad);
        centred = 1'b1;
      end
      KIND_CROSS: begin
        r = q_plus(hi_of(c[2], c[3]), pad);
        centred = 1'b1;
      end
      KIND_ROUNDX: begin
        r = q_plus(q_plus(c[2], c[3]), pad);
        centred = 1'b1;
      end
      KIND_CAPSULE: begin
        r  = q_plus(c[4], pad);
        x0 = q_minus(lo_of(c[0], c[2]), r);
        y0 = q_minus(lo_of(c[1], c[3]), r);
        x1 = q_plus(hi_of(c[0], c[2]), r);
        y1 = q_plus(hi_of(c[1], c[3]), r);
      end
      KIND_MOON: begin
        r  = q_plus(hi_of(c[3], c[4]), pad);
        x0 = q_minus(c[0], r);
        y0 = q_minus(c[1], r);
        x1 = q_plus(q_plus(c[0], r), c[2]);
        y1 = q_plus(c[1], r);
      end
      KIND_EGG: begin
        r  = q_plus(hi_of(c[2], c[3]), pad);
        x0 = q_minus(c[0], r);
        y0 = q_minus(c[1], r);
        x1 = q_plus(c[0], r);
        y1 = q_plus(q_plus(c[1], r), c[2]);
      end
      default: ;
    endcase
    if (centred) begin
      hw = r;
      hh = r;
      boxed = 1'b1;
    end
    if (boxed) begin
      x0 = q_minus(c[0], hw);
      y0 = q_minus(c[1], hh);
      x1 = q_plus(c[0], hw);
      y1 = q_plus(c[1], hh);
    end
    b.min_x = 32'(x0);
    b.min_y = 32'(y0);
    b.max_x = 32'(x1);
    b.max_y = 32'(y1);
    return b;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i) begin
    sbb_box_t got, want;
    if (rst_ni) begin
      if (box_i.valid && box_i.ready) begin
        got = {box_i.min_x, box_i.min_y, box_i.max_x, box_i.max_y};
        if (box_q.size() == 0) begin
          report_mismatch("box with no transfer in", got.min_x, '0);
        end else begin
          want = box_q.pop_front();
          if (got.min_x !== want.min_x) report_mismatch("min_x", got.min_x, want.min_x);
          if (got.min_y !== want.min_y) report_mismatch("min_y", got.min_y, want.min_y);
          if (got.max_x !== want.max_x) report_mismatch("max_x", got.max_x, want.max_x);
          if (got.max_y !== want.max_y) report_mismatch("max_y", got.max_y, want.max_y);
        end
      end
      if (prim_i.valid && prim_i.ready) begin
        box_q.insert(box_q.size(),
                     bbox_of({prim_i.shape_kind, prim_i.param_0, prim_i.param_1,
                              prim_i.param_2, prim_i.param_3, prim_i.param_4,
                              prim_i.param_5, prim_i.param_6, prim_i.param_7,
                              prim_i.stroke_width, prim_i.corner_round}));
      end
      pending_o = box_q.size();
    end
  end

endmodule

@@ tb/shape_bounding_box_test.sv @@
`timescale 1ns / 100ps
// Testbench top for the bounding box block: clock, reset, primitive stimulus and verdict.
module shape_bounding_box_test;
  import sbb_pkg::*;

  localparam int HalfPeriod = 10;
  localparam int HoldCycles = 300;

  logic clk;
  logic rst_n;
  logic prim_taken_q = 1'b0;
  int   fail_count;
  int   pending;
  int   send_idle_pct  = 8;
  int   recv_stall_pct = 55;
  int   hold_asked     = 0;
  int   hold_done      = 0;

  sbb_in_if  in_ch ();
  sbb_out_if out_ch ();

  shape_bounding_box u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  shape_bounding_box_checker u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .prim_i       (in_ch),
    .box_i        (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #HalfPeriod clk = ~clk;
  end

  always @(posedge clk) prim_taken_q <= in_ch.valid && in_ch.ready;

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asked != hold_done) begin
        hold_done++;
        out_ch.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end
      out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [31:0] small_q();
    return 32'($urandom_range(32'h0040_0000)) - 32'h0020_0000;
  endfunction

  function automatic logic [31:0] pick_q();
    case ($urandom_range(9))
      0: return QMin;
      1: return QMax;
      2: return '0;
      3, 4, 5: return small_q();
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [WidW-1:0] pick_w();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2, 3, 4: return WidW'($urandom_range(32'h0008_0000));
      default: return WidW'($urandom());
    endcase
  endfunction

  function automatic sbb_prim_t random_prim(input logic [KindW-1:0] kind, input bit tame);
    sbb_prim_t p;
    p.shape_kind   = kind;
    p.param_0      = tame ? small_q() : pick_q();
    p.param_1      = tame ? small_q() : pick_q();
    p.param_2      = tame ? small_q() : pick_q();
    p.param_3      = tame ? small_q() : pick_q();
    p.param_4      = tame ? small_q() : pick_q();
    p.param_5      = tame ? small_q() : pick_q();
    p.param_6      = tame ? small_q() : pick_q();
    p.param_7      = tame ? small_q() : pick_q();
    p.stroke_width = tame ? WidW'($urandom_range(32'h0004_0000)) : pick_w();
    p.corner_round = tame ? WidW'($urandom_range(32'h0002_0000)) : pick_w();
    return p;
  endfunction

  function automatic sbb_prim_t flat_prim(input logic [KindW-1:0] kind,
                                          input logic [31:0] v);
    sbb_prim_t p;
    p = {kind, {8{v}}, {WidW{1'b1}}, {WidW{1'b1}}};
    return p;
  endfunction

  function automatic logic [KindW-1:0] pick_kind();
    if ($urandom_range(99) < 10) return KindW'($urandom_range(31, 20));
    return KindW'($urandom_range(19));
  endfunction

  task automatic put_prim(input sbb_prim_t p);
    in_ch.shape_kind   = p.shape_kind;
    in_ch.param_0      = p.param_0;
    in_ch.param_1      = p.param_1;
    in_ch.param_2      = p.param_2;
    in_ch.param_3      = p.param_3;
    in_ch.param_4      = p.param_4;
    in_ch.param_5      = p.param_5;
    in_ch.param_6      = p.param_6;
    in_ch.param_7      = p.param_7;
    in_ch.stroke_width = p.stroke_width;
    in_ch.corner_round = p.corner_round;
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_prim(input sbb_prim_t p);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    put_prim(p);
    in_ch.valid = 1'b1;
    do @(negedge clk); while (!prim_taken_q);
  endtask

  task automatic drain_boxes();
    in_ch.valid = 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic random_run(input int count, input int hold_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_asked++;
      send_prim(random_prim(pick_kind(), 1'b0));
    end
    drain_boxes();
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    put_prim('0);
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int k = 0; k <= int'(KIND_EGG); k++) begin
      send_prim(random_prim(KindW'(k), 1'b1));
    end
    send_prim(flat_prim(KIND_BOX, QMax));
    send_prim(flat_prim(KIND_HEART, QMax));
    send_prim(flat_prim(KIND_HEART, QMin));
    send_prim(flat_prim(KIND_MOON, QMin));
    send_prim(random_prim(5'd31, 1'b0));
    drain_boxes();

    random_run(300, 100);

    send_idle_pct  = 55;
    recv_stall_pct = 8;
    random_run(300, 150);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_run(200, -1);

    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
